// File: hdl/sdb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the spectrum dB averager.
// No dependencies; imported by every module of the block.
package sdb_pkg;

   // Level store geometry (depth must be a power of two)
   localparam int STORE_DEPTH = 65536;
   localparam int IDX_W       = $clog2(STORE_DEPTH);

   // Field widths
   localparam int BIN_W    = 24;
   localparam int POS_W    = 16;
   localparam int LEVEL_W  = 18;
   localparam int WEIGHT_W = 9;
   localparam int FRAME_W  = 4;

   // Power and log2 datapath
   localparam int MAG_W       = BIN_W;          // |-2^23| still fits unsigned
   localparam int POWER_W     = 2 * MAG_W;      // re^2 + im^2 < 2^48
   localparam int EXP_W       = $clog2(POWER_W);
   localparam int MANT_W      = 32;             // Q1.31 mantissa
   localparam int FRAC_BITS   = 16;             // log2 fraction bits
   localparam int NORM_OFFSET = 16;             // log2 of the 65536 scale
   localparam int LEVEL_SHIFT = 24;             // Q16 * Q16 -> Q8

   // 20*log10(2) in Q16
   localparam int DB_K_W = 20;
   localparam logic signed [DB_K_W-1:0] DB_PER_OCTAVE_Q16 = 20'sd394566;

   // Level range and reset value, 1/256 dB
   localparam int LEVEL_RESET_DB = -110;
   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN   = {1'b1, {(LEVEL_W-1){1'b0}}};
   localparam logic signed [LEVEL_W-1:0] LEVEL_MAX   = {1'b0, {(LEVEL_W-1){1'b1}}};
   localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(LEVEL_RESET_DB * 256);

   // Register limits and reset values
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = 9'd256;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 9'd205;
   localparam logic [FRAME_W-1:0]  FRAME_LOG2_MIN  = 4'd4;
   localparam logic [FRAME_W-1:0]  FRAME_LOG2_MAX  = 4'd12;
   localparam logic [FRAME_W-1:0]  FRAME_LOG2_RESET = 4'd11;

   // Queue between front and back
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = WEIGHT_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AVG_WEIGHT = 4'd0,
      CSR_FRAME_LOG2 = 4'd1
   } csr_index_type;

   // One finished level on its way to the store
   typedef struct packed {
      logic [POS_W-1:0]          pos;
      logic signed [LEVEL_W-1:0] level;
   } level_item_type;

   // Back-end status seen by the front end
   typedef struct packed {
      logic busy;   // clearing pass running
      logic pop;    // one queue entry taken this cycle
   } back_status_type;

   // Store index: position modulo the (power of two) store depth
   function automatic logic [IDX_W-1:0] store_index(input logic [POS_W-1:0] pos);
      logic [POS_W+IDX_W-1:0] wide;
      wide = (POS_W + IDX_W)'(pos);
      return wide[IDX_W-1:0];
   endfunction

endpackage

// File: hdl/spectrum_db_averager.sv
`timescale 1ns / 1ps
// Spectrum dB averager: exponentially averaged log-power store.
// A bin passes the front pipeline, queue, and back-end read and result registers.
// Throughput: one bin per clock while not stalled; the store forwards its last write.
// Reset: synchronous; registers return to avg_weight 205, frame_log2 11, and a
// clearing pass over STORE_DEPTH (65536) entries writes -110 dB with req_stall high.
module spectrum_db_averager
   import sdb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // input beats
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [BIN_W-1:0]   req_bin_re,
   input  logic signed [BIN_W-1:0]   req_bin_im,
   input  logic [POS_W-1:0]          req_position,
   // result beats
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [POS_W-1:0]          rsp_out_position,
   output logic signed [LEVEL_W-1:0] rsp_avg_level,
   // configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   // configuration registers, held already clamped to their legal range
   logic [WEIGHT_W-1:0] avg_weight_ff, avg_weight_in;
   logic [FRAME_W-1:0]  frame_log2_ff, frame_log2_in;
   logic [FRAME_W-1:0]  frame_wdata;

   assign csr_ready   = 1'b1;
   assign frame_wdata = csr_wdata[FRAME_W-1:0];

   always_comb begin
      avg_weight_in = avg_weight_ff;
      frame_log2_in = frame_log2_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AVG_WEIGHT: begin
               avg_weight_in = (csr_wdata > WEIGHT_ONE) ? WEIGHT_ONE : csr_wdata;
            end
            CSR_FRAME_LOG2: begin
               if (frame_wdata < FRAME_LOG2_MIN)      frame_log2_in = FRAME_LOG2_MIN;
               else if (frame_wdata > FRAME_LOG2_MAX) frame_log2_in = FRAME_LOG2_MAX;
               else                                   frame_log2_in = frame_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_weight_ff <= WEIGHT_RESET;
         frame_log2_ff <= FRAME_LOG2_RESET;
      end else begin
         avg_weight_ff <= avg_weight_in;
         frame_log2_ff <= frame_log2_in;
      end
   end

   back_status_type back_status;
   logic            push_valid;
   level_item_type  push_item;
   level_item_type  head_item;
   logic            not_empty;

   sdb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_bin_re   (req_bin_re),
      .req_bin_im   (req_bin_im),
      .req_position (req_position),
      .frame_log2   (frame_log2_ff),
      .back_status  (back_status),
      .push_valid   (push_valid),
      .push_item    (push_item)
   );

   sdb_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (back_status.pop),
      .head_item  (head_item),
      .not_empty  (not_empty)
   );

   sdb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .avg_weight       (avg_weight_ff),
      .head_item        (head_item),
      .not_empty        (not_empty),
      .status           (back_status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_position (rsp_out_position),
      .rsp_avg_level    (rsp_avg_level)
   );

endmodule

// File: hdl/sdb_log2.sv
`timescale 1ns / 1ps
// Pipelined log2 of the bin power: two-stage leading-one normalize, then
// one squaring stage per fraction bit. Depends on sdb_pkg.
module sdb_log2
   import sdb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [POWER_W-1:0]   in_power,
   input  logic [POS_W-1:0]     in_pos,
   output logic                 out_valid,
   output logic                 out_zero,
   output logic [EXP_W-1:0]     out_expo,
   output logic [FRAC_BITS-1:0] out_frac,
   output logic [POS_W-1:0]     out_pos
);

   localparam int GROUP_W     = 8;
   localparam int GROUP_N     = POWER_W / GROUP_W;
   localparam int GROUP_SEL_W = $clog2(GROUP_N);
   localparam int GBIT_W      = $clog2(GROUP_W);

   typedef struct packed {
      logic                 zero;
      logic [EXP_W-1:0]     expo;
      logic [POS_W-1:0]     pos;
      logic [MANT_W-1:0]    mant;
      logic [FRAC_BITS-1:0] frac;
   } log_stage_type;

   // coarse normalize: highest nonzero byte
   logic [GROUP_SEL_W-1:0] grp;
   logic [EXP_W-1:0]       coarse_amt;
   logic [POWER_W-1:0]     n1_shift_in;
   logic                   n1_valid_ff;
   logic [POWER_W-1:0]     n1_shift_ff;
   logic [GROUP_SEL_W-1:0] n1_grp_ff;
   logic                   n1_zero_ff;
   logic [POS_W-1:0]       n1_pos_ff;

   always_comb begin
      grp = '0;
      for (int g = 0; g < GROUP_N; g++) begin
         if (in_power[g*GROUP_W +: GROUP_W] != '0) grp = GROUP_SEL_W'(g);
      end
      coarse_amt  = {GROUP_SEL_W'(GROUP_N - 1) - grp, GBIT_W'(0)};
      n1_shift_in = in_power << coarse_amt;
   end

   always_ff @(posedge clock) begin
      if (reset) n1_valid_ff <= 1'b0;
      else       n1_valid_ff <= in_valid;
      n1_shift_ff <= n1_shift_in;
      n1_grp_ff   <= grp;
      n1_zero_ff  <= (in_power == '0);
      n1_pos_ff   <= in_pos;
   end

   // fine normalize: leading one inside the top byte
   logic [GROUP_W-1:0] top_byte;
   logic [GBIT_W-1:0]  bitpos;
   logic [GBIT_W-1:0]  fine_amt;
   logic [POWER_W-1:0] norm;
   log_stage_type      stage0_in;

   logic               valid_ff [0:FRAC_BITS];
   log_stage_type      stage_ff [0:FRAC_BITS];

   always_comb begin
      top_byte = n1_shift_ff[POWER_W-1 -: GROUP_W];
      bitpos   = '0;
      for (int b = 0; b < GROUP_W; b++) begin
         if (top_byte[b]) bitpos = GBIT_W'(b);
      end
      fine_amt        = GBIT_W'(GROUP_W - 1) - bitpos;
      norm            = n1_shift_ff << fine_amt;
      stage0_in.zero  = n1_zero_ff;
      stage0_in.expo  = EXP_W'({n1_grp_ff, bitpos});
      stage0_in.pos   = n1_pos_ff;
      stage0_in.mant  = norm[POWER_W-1 -: MANT_W];
      stage0_in.frac  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else       valid_ff[0] <= n1_valid_ff;
      stage_ff[0] <= stage0_in;
   end

   // one fraction bit per stage: square, renormalize
   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_square
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     scaled;
      log_stage_type       square_in;

      always_comb begin
         sq        = (2*MANT_W)'(stage_ff[i].mant) * (2*MANT_W)'(stage_ff[i].mant);
         scaled    = sq[2*MANT_W-1 : MANT_W-1];
         square_in = stage_ff[i];
         square_in.mant = scaled[MANT_W] ? scaled[MANT_W:1] : scaled[MANT_W-1:0];
         square_in.frac = {stage_ff[i].frac[FRAC_BITS-2:0], scaled[MANT_W]};
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[i+1] <= 1'b0;
         else       valid_ff[i+1] <= valid_ff[i];
         stage_ff[i+1] <= square_in;
      end
   end

   assign out_valid = valid_ff[FRAC_BITS];
   assign out_zero  = stage_ff[FRAC_BITS].zero;
   assign out_expo  = stage_ff[FRAC_BITS].expo;
   assign out_frac  = stage_ff[FRAC_BITS].frac;
   assign out_pos   = stage_ff[FRAC_BITS].pos;

endmodule

// File: hdl/sdb_front.sv
`timescale 1ns / 1ps
// Front end: accepts bins, forms power, log2 and the dB level, and pushes
// finished levels into the queue under credit. Depends on sdb_pkg, sdb_log2.
module sdb_front
   import sdb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [BIN_W-1:0] req_bin_re,
   input  logic signed [BIN_W-1:0] req_bin_im,
   input  logic [POS_W-1:0]        req_position,
   input  logic [FRAME_W-1:0]      frame_log2,
   input  back_status_type         back_status,
   output logic                    push_valid,
   output level_item_type          push_item
);

   localparam int DINT_W = EXP_W + 1;
   localparam int D_W    = DINT_W + FRAC_BITS;
   localparam int PROD_W = D_W + DB_K_W;
   localparam int RND_W  = PROD_W - LEVEL_SHIFT;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (LEVEL_SHIFT - 1);

   // credit: beats accepted and not yet popped from the queue
   logic             accept;
   logic [CNT_W-1:0] inflight_ff, inflight_in;

   assign accept    = req_valid && !req_stall;
   assign req_stall = back_status.busy || (inflight_ff == CNT_W'(FIFO_DEPTH));
   assign inflight_in = inflight_ff + CNT_W'(accept) - CNT_W'(back_status.pop);

   always_ff @(posedge clock) begin
      if (reset) inflight_ff <= '0;
      else       inflight_ff <= inflight_in;
   end

   // magnitudes
   logic [MAG_W-1:0] mag_re_in, mag_im_in;
   logic             mag_valid_ff;
   logic [MAG_W-1:0] mag_re_ff, mag_im_ff;
   logic [POS_W-1:0] mag_pos_ff;

   assign mag_re_in = req_bin_re[BIN_W-1] ? MAG_W'(-req_bin_re) : MAG_W'(req_bin_re);
   assign mag_im_in = req_bin_im[BIN_W-1] ? MAG_W'(-req_bin_im) : MAG_W'(req_bin_im);

   always_ff @(posedge clock) begin
      if (reset) mag_valid_ff <= 1'b0;
      else       mag_valid_ff <= accept;
      mag_re_ff  <= mag_re_in;
      mag_im_ff  <= mag_im_in;
      mag_pos_ff <= req_position;
   end

   // squares
   logic               sq_valid_ff;
   logic [POWER_W-1:0] sq_re_ff, sq_im_ff;
   logic [POS_W-1:0]   sq_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) sq_valid_ff <= 1'b0;
      else       sq_valid_ff <= mag_valid_ff;
      sq_re_ff  <= POWER_W'(mag_re_ff) * POWER_W'(mag_re_ff);
      sq_im_ff  <= POWER_W'(mag_im_ff) * POWER_W'(mag_im_ff);
      sq_pos_ff <= mag_pos_ff;
   end

   // power sum
   logic               pwr_valid_ff;
   logic [POWER_W-1:0] pwr_ff;
   logic [POS_W-1:0]   pwr_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) pwr_valid_ff <= 1'b0;
      else       pwr_valid_ff <= sq_valid_ff;
      pwr_ff     <= sq_re_ff + sq_im_ff;
      pwr_pos_ff <= sq_pos_ff;
   end

   logic                 lg_valid, lg_zero;
   logic [EXP_W-1:0]     lg_expo;
   logic [FRAC_BITS-1:0] lg_frac;
   logic [POS_W-1:0]     lg_pos;

   sdb_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pwr_valid_ff),
      .in_power  (pwr_ff),
      .in_pos    (pwr_pos_ff),
      .out_valid (lg_valid),
      .out_zero  (lg_zero),
      .out_expo  (lg_expo),
      .out_frac  (lg_frac),
      .out_pos   (lg_pos)
   );

   // remove frame normalization, scale to dB
   logic [DINT_W-1:0]        norm_ofs;
   logic [DINT_W-1:0]        dint;
   logic signed [D_W-1:0]    dlog;
   logic signed [PROD_W-1:0] scl_prod_in;
   logic                     scl_valid_ff, scl_zero_ff;
   logic signed [PROD_W-1:0] scl_prod_ff;
   logic [POS_W-1:0]         scl_pos_ff;

   always_comb begin
      norm_ofs    = DINT_W'({frame_log2, 1'b0}) + DINT_W'(NORM_OFFSET);
      dint        = DINT_W'(lg_expo) - norm_ofs;
      dlog        = $signed({dint, lg_frac});
      scl_prod_in = dlog * DB_PER_OCTAVE_Q16;
   end

   always_ff @(posedge clock) begin
      if (reset) scl_valid_ff <= 1'b0;
      else       scl_valid_ff <= lg_valid;
      scl_zero_ff <= lg_zero;
      scl_prod_ff <= scl_prod_in;
      scl_pos_ff  <= lg_pos;
   end

   // round to Q8, clamp, zero power goes to the floor
   logic signed [PROD_W-1:0]  rnd_sum;
   logic signed [RND_W-1:0]   rnd;
   logic signed [LEVEL_W-1:0] lvl_level_in;
   logic                      lvl_valid_ff;
   logic signed [LEVEL_W-1:0] lvl_level_ff;
   logic [POS_W-1:0]          lvl_pos_ff;

   always_comb begin
      rnd_sum = scl_prod_ff + ROUND_HALF;
      rnd     = rnd_sum[PROD_W-1:LEVEL_SHIFT];
      if (scl_zero_ff)            lvl_level_in = LEVEL_MIN;
      else if (rnd < LEVEL_MIN)   lvl_level_in = LEVEL_MIN;
      else if (rnd > LEVEL_MAX)   lvl_level_in = LEVEL_MAX;
      else                        lvl_level_in = rnd[LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) lvl_valid_ff <= 1'b0;
      else       lvl_valid_ff <= scl_valid_ff;
      lvl_level_ff <= lvl_level_in;
      lvl_pos_ff   <= scl_pos_ff;
   end

   assign push_valid      = lvl_valid_ff;
   assign push_item.pos   = lvl_pos_ff;
   assign push_item.level = lvl_level_ff;

endmodule

// File: hdl/sdb_fifo.sv
`timescale 1ns / 1ps
// Short queue of finished levels between front and back end.
// Space is guaranteed by the front-end credit count. Depends on sdb_pkg.
module sdb_fifo
   import sdb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  level_item_type push_item,
   input  logic           pop,
   output level_item_type head_item,
   output logic           not_empty
);

   level_item_type     entries_ff [0:FIFO_DEPTH-1];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign count_in  = count_ff + CNT_W'(push_valid) - CNT_W'(pop);
   assign not_empty = (count_ff != '0);
   assign head_item = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         if (pop)        rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) entries_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// File: hdl/sdb_back.sv
`timescale 1ns / 1ps
// Back end: level store read-modify-write with the exponential blend,
// result register and post-reset clearing pass. Depends on sdb_pkg.
module sdb_back
   import sdb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [WEIGHT_W-1:0]       avg_weight,
   input  level_item_type            head_item,
   input  logic                      not_empty,
   output back_status_type           status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [POS_W-1:0]          rsp_out_position,
   output logic signed [LEVEL_W-1:0] rsp_avg_level
);

   localparam int T_W   = 28;
   localparam int SUM_W = T_W - 8;
   localparam logic signed [T_W-1:0] BLEND_HALF = T_W'(128);

   logic signed [LEVEL_W-1:0] store [0:STORE_DEPTH-1];

   // clearing pass after reset
   logic             clearing_ff;
   logic [IDX_W-1:0] clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
      end else if (clearing_ff) begin
         clear_cnt_ff <= clear_cnt_ff + IDX_W'(1);
         if (clear_cnt_ff == IDX_W'(STORE_DEPTH - 1)) clearing_ff <= 1'b0;
      end
   end

   // whole back pipeline moves when the result register can take a beat
   logic             advance, pop;
   logic [IDX_W-1:0] head_idx;

   assign advance  = !rsp_valid || !rsp_stall;
   assign pop      = advance && not_empty && !clearing_ff;
   assign head_idx = store_index(head_item.pos);

   assign status.busy = clearing_ff;
   assign status.pop  = pop;

   // read stage: fetch old level, precompute (1-w)*level + rounding half
   logic [WEIGHT_W-1:0]       comp_w;
   logic signed [T_W-1:0]     rd_t_in;
   logic                      rd_valid_ff;
   logic [POS_W-1:0]          rd_pos_ff;
   logic signed [T_W-1:0]     rd_t_ff;
   logic signed [LEVEL_W-1:0] rd_data_ff;

   always_comb begin
      comp_w  = WEIGHT_ONE - avg_weight;
      rd_t_in = $signed({1'b0, comp_w}) * head_item.level + BLEND_HALF;
   end

   always_ff @(posedge clock) begin
      if (reset)        rd_valid_ff <= 1'b0;
      else if (advance) rd_valid_ff <= pop;
      if (pop) begin
         rd_pos_ff  <= head_item.pos;
         rd_t_ff    <= rd_t_in;
         rd_data_ff <= store[head_idx];
      end
   end

   // blend stage: forward the previous write if it hit the same entry
   logic [IDX_W-1:0]          rd_idx;
   logic                      last_valid_ff;
   logic [IDX_W-1:0]          last_idx_ff;
   logic signed [LEVEL_W-1:0] last_val_ff;
   logic signed [LEVEL_W-1:0] old_level;
   logic signed [T_W-1:0]     blend_sum;
   logic signed [SUM_W-1:0]   blend_rnd;
   logic signed [LEVEL_W-1:0] new_level_in;
   logic                      wr_en;

   always_comb begin
      rd_idx    = store_index(rd_pos_ff);
      old_level = (last_valid_ff && (last_idx_ff == rd_idx)) ? last_val_ff : rd_data_ff;
      blend_sum = $signed({1'b0, avg_weight}) * old_level + rd_t_ff;
      blend_rnd = blend_sum[T_W-1:8];
      if (blend_rnd < LEVEL_MIN)      new_level_in = LEVEL_MIN;
      else if (blend_rnd > LEVEL_MAX) new_level_in = LEVEL_MAX;
      else                            new_level_in = blend_rnd[LEVEL_W-1:0];
      wr_en = advance && rd_valid_ff;
   end

   // result register and last-write record
   logic                      out_valid_ff;
   logic [POS_W-1:0]          out_pos_ff;
   logic signed [LEVEL_W-1:0] out_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         last_valid_ff <= 1'b0;
      end else begin
         if (advance) out_valid_ff <= rd_valid_ff;
         if (wr_en)   last_valid_ff <= 1'b1;
      end
      if (wr_en) begin
         out_pos_ff   <= rd_pos_ff;
         out_level_ff <= new_level_in;
         last_idx_ff  <= rd_idx;
         last_val_ff  <= new_level_in;
      end
   end

   // store write port: clearing pass or blended result
   always_ff @(posedge clock) begin
      if (clearing_ff)  store[clear_cnt_ff] <= LEVEL_RESET;
      else if (wr_en)   store[rd_idx]       <= new_level_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_position = out_pos_ff;
   assign rsp_avg_level    = out_level_ff;

endmodule

// File: hdl/sdb_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the spectrum dB averager, bound to the top level.
// Depends on sdb_pkg and spectrum_db_averager.
module sdb_checker
   import sdb_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [POS_W-1:0]          rsp_out_position,
   input logic signed [LEVEL_W-1:0] rsp_avg_level
);

   // beats accepted and not yet delivered: front-end credit plus two back-end registers
   localparam int LIMIT = FIFO_DEPTH + 2;
   localparam int OUT_W = $clog2(LIMIT + 2);

   logic             req_beat, rsp_beat;
   logic [OUT_W-1:0] outstanding_ff, outstanding_in;

   assign req_beat       = req_valid && !req_stall;
   assign rsp_beat       = rsp_valid && !rsp_stall;
   assign outstanding_in = outstanding_ff + OUT_W'(req_beat) - OUT_W'(rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) outstanding_ff <= '0;
      else       outstanding_ff <= outstanding_in;
   end

   // clearing pass holds off input right after reset
   a_stall_after_reset: assert property (@(posedge clock) $past(reset) |-> req_stall)
      else $error("req_stall low right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a result only for a beat that was taken
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("result with no outstanding input beat");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OUT_W'(LIMIT))
      else $error("more beats in flight than the queue can hold");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_avg_level)
                                 && $stable(rsp_out_position))
      else $error("stalled result changed");

endmodule

bind spectrum_db_averager sdb_checker u_checker (.*);

// File: bench/sdb_level_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the spectrum dB averager: watches the bin, result and register beats.
// It predicts every averaged level and compares the results in order.
// Depends on sdb_pkg for port widths and register index names.
module sdb_level_checker
   import sdb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [BIN_W-1:0]   req_bin_re,
   input  logic signed [BIN_W-1:0]   req_bin_im,
   input  logic [POS_W-1:0]          req_position,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [POS_W-1:0]          rsp_out_position,
   input  logic signed [LEVEL_W-1:0] rsp_avg_level,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   output int                        mismatch_count,
   output int                        pending_count,
   output int                        checked_count
);

   // 20*log10(2) in Q16, level limits and cleared value in 1/256 dB
   localparam longint DB_PER_OCTAVE   = 394566;
   localparam longint LEVEL_FLOOR     = -131072;
   localparam longint LEVEL_CEILING   = 131071;
   localparam longint LEVEL_CLEARED   = -28160;
   localparam int     FULL_WEIGHT     = 256;
   localparam int     FRAME_LOG2_LOW  = 4;
   localparam int     FRAME_LOG2_HIGH = 12;
   localparam logic [WEIGHT_W-1:0] WEIGHT_AT_RESET = 9'd205;
   localparam logic [FRAME_W-1:0]  FRAME_AT_RESET  = 4'd11;

   logic signed [LEVEL_W-1:0] level_mem [STORE_DEPTH];
   logic [WEIGHT_W-1:0]       weight_setting;
   logic [FRAME_W-1:0]        frame_setting;
   level_item_type            level_queue [$];

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) level_mem[i] = LEVEL_W'(LEVEL_CLEARED);
   end

   function automatic logic signed [LEVEL_W-1:0] saturate(input longint value);
      if (value < LEVEL_FLOOR) return LEVEL_W'(LEVEL_FLOOR);
      if (value > LEVEL_CEILING) return LEVEL_W'(LEVEL_CEILING);
      return LEVEL_W'(value);
   endfunction

   // log2 in Q16: msb index plus 16 fraction bits from repeated squaring
   function automatic longint log2_fixed(input logic [POWER_W-1:0] power);
      int              msb;
      logic [63:0]     mant;
      logic [15:0]     frac;
      msb = 0;
      frac = '0;
      for (int b = 0; b < POWER_W; b++) if (power[b]) msb = b;
      if (msb >= 31) mant = 64'(power) >> (msb - 31);
      else mant = 64'(power) << (31 - msb);
      for (int i = 0; i < 16; i++) begin
         mant = (mant * mant) >> 31;
         frac = {frac[14:0], 1'b0};
         if (mant >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      return (longint'(msb) <<< 16) + longint'({48'd0, frac});
   endfunction

   // normalized dB level of one bin
   function automatic logic signed [LEVEL_W-1:0] bin_level(
      input logic signed [BIN_W-1:0] re,
      input logic signed [BIN_W-1:0] im,
      input logic [FRAME_W-1:0]      frame
   );
      logic [BIN_W-1:0]   mag_re;
      logic [BIN_W-1:0]   mag_im;
      logic [POWER_W-1:0] power;
      int                 fl2;
      longint             diff;
      fl2 = int'(frame);
      if (fl2 < FRAME_LOG2_LOW) fl2 = FRAME_LOG2_LOW;
      if (fl2 > FRAME_LOG2_HIGH) fl2 = FRAME_LOG2_HIGH;
      mag_re = (re < 0) ? -re : re;
      mag_im = (im < 0) ? -im : im;
      power = mag_re * mag_re + mag_im * mag_im;
      if (power == '0) return LEVEL_W'(LEVEL_FLOOR);
      diff = log2_fixed(power) - (longint'(2 * fl2 + 16) <<< 16);
      return saturate((diff * DB_PER_OCTAVE + (longint'(1) <<< 23)) >>> 24);
   endfunction

   // exponential blend; weights above one keep the old value
   function automatic logic signed [LEVEL_W-1:0] blended_level(
      input logic signed [LEVEL_W-1:0] old_level,
      input logic signed [LEVEL_W-1:0] new_level,
      input logic [WEIGHT_W-1:0]       weight
   );
      int     w;
      longint sum;
      w = int'(weight);
      if (w > FULL_WEIGHT) w = FULL_WEIGHT;
      sum = longint'(w) * longint'(old_level) + longint'(FULL_WEIGHT - w) * longint'(new_level);
      return saturate((sum + 128) >>> 8);
   endfunction

   always @(posedge clock) begin : scoreboard
      level_item_type            expected_item;
      logic signed [LEVEL_W-1:0] updated;
      int                        slot;
      int                        fresh_errors;
      int                        fresh_checks;
      fresh_errors = 0;
      fresh_checks = 0;
      if (reset) begin
         weight_setting = WEIGHT_AT_RESET;
         frame_setting = FRAME_AT_RESET;
      end else begin
         // register beat; unknown indexes leave both settings alone
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_AVG_WEIGHT) weight_setting = csr_wdata;
            else if (csr_index == CSR_FRAME_LOG2) frame_setting = csr_wdata[FRAME_W-1:0];
         end
         // bin beat: update the model store and queue the expected level
         if (req_valid && !req_stall) begin
            slot = int'(req_position) % STORE_DEPTH;
            updated = blended_level(level_mem[slot],
                                    bin_level(req_bin_re, req_bin_im, frame_setting),
                                    weight_setting);
            level_mem[slot] = updated;
            expected_item.pos = req_position;
            expected_item.level = updated;
            level_queue.push_back(expected_item);
         end
         // result beat
         if (rsp_valid && !rsp_stall) begin
            if (level_queue.size() == 0) begin
               $display("%0t: result with nothing expected, position %0d level %0d",
                        $time, rsp_out_position, rsp_avg_level);
               fresh_errors++;
            end else begin
               expected_item = level_queue.pop_front();
               fresh_checks++;
               if (rsp_out_position !== expected_item.pos) begin
                  $display("%0t: out_position mismatch, expected %0d, actual %0d",
                           $time, expected_item.pos, rsp_out_position);
                  fresh_errors++;
               end
               if (rsp_avg_level !== expected_item.level) begin
                  $display("%0t: avg_level mismatch at position %0d, expected %0d, actual %0d",
                           $time, expected_item.pos, expected_item.level, rsp_avg_level);
                  fresh_errors++;
               end
            end
         end
      end
      mismatch_count <= mismatch_count + fresh_errors;
      checked_count <= checked_count + fresh_checks;
      pending_count <= level_queue.size();
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the spectrum dB averager bench: clock, reset, bin and register stimulus,
// result back-pressure and the verdict. Depends on sdb_pkg and sdb_level_checker.
module testbench
   import sdb_pkg::*;
();

   localparam int RESET_CYCLES    = 11;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_ITEMS     = 160;
   localparam int PRESSURE_PHASE  = 1;
   localparam int PRESSURE_ITEMS  = 120;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 64;
   localparam int WATCHDOG_LIMIT  = 300000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 4'd9;
   localparam logic signed [BIN_W-1:0] BIN_MOST_NEG = {1'b1, {(BIN_W-1){1'b0}}};
   localparam logic signed [BIN_W-1:0] BIN_MOST_POS = {1'b0, {(BIN_W-1){1'b1}}};

   // settings per phase; the last phase draws its own
   localparam logic [WEIGHT_W-1:0] PHASE_WEIGHT [PHASE_COUNT] =
      '{9'd0, 9'd256, 9'd511, 9'd257, 9'd128, 9'd1, 9'd255, 9'd205};
   localparam logic [FRAME_W-1:0] PHASE_FRAME [PHASE_COUNT] =
      '{4'd4, 4'd12, 4'd15, 4'd0, 4'd3, 4'd13, 4'd8, 4'd11};

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [BIN_W-1:0]   req_bin_re;
   logic signed [BIN_W-1:0]   req_bin_im;
   logic [POS_W-1:0]          req_position;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [POS_W-1:0]          rsp_out_position;
   logic signed [LEVEL_W-1:0] rsp_avg_level;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   int               mismatch_count;
   int               pending_count;
   int               checked_count;
   int               hold_off_requests = 0;
   int               bins_sent = 0;
   bit               send_burst;
   logic [POS_W-1:0] last_position = '0;

   always #2 clock = ~clock;

   spectrum_db_averager DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_bin_re       (req_bin_re),
      .req_bin_im       (req_bin_im),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_position (rsp_out_position),
      .rsp_avg_level    (rsp_avg_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   sdb_level_checker level_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_bin_re       (req_bin_re),
      .req_bin_im       (req_bin_im),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_position (rsp_out_position),
      .rsp_avg_level    (rsp_avg_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   // one bin beat; valid stays high into the next beat when there is no gap
   task automatic send_bin(
      input logic signed [BIN_W-1:0] re,
      input logic signed [BIN_W-1:0] im,
      input logic [POS_W-1:0]        pos
   );
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_bin_re <= re;
      req_bin_im <= im;
      req_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bins_sent++;
      last_position = pos;
   endtask

   // register beat; the caller lowers valid after the last one
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // stop offering bins and wait for every expected level
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // mix of zero, full scale, full random and small magnitudes
   function automatic logic signed [BIN_W-1:0] random_component();
      logic signed [BIN_W-1:0] raw;
      raw = BIN_W'($urandom);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return $urandom_range(0, 1) ? BIN_MOST_NEG : BIN_MOST_POS;
         2, 3, 4: return raw;
         default: return raw >>> $urandom_range(1, BIN_W - 1);
      endcase
   endfunction

   // hot entries and repeats keep the store read-modify-write busy
   function automatic logic [POS_W-1:0] random_position();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return POS_W'($urandom_range(0, 15));
         5: return last_position;
         default: return POS_W'($urandom);
      endcase
   endfunction

   // result side: random stall per beat, bursts, and one long hold-off on request
   initial begin : result_sink
      int stall_cycles;
      int hold_offs_done;
      bit take_burst;
      hold_offs_done = 0;
      take_burst = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
         stall_cycles = take_burst ? 0 : $urandom_range(0, 16);
         if (hold_off_requests > hold_offs_done) begin
            stall_cycles = HOLD_OFF_CYCLES;
            hold_offs_done++;
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // ends the run when no beat moves on any channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no beat moved for %0d cycles, %0d levels outstanding",
               $time, quiet, pending_count);
      $display("testbench failed");
      $finish;
   end

   initial begin : stimulus
      logic [WEIGHT_W-1:0] weight;
      logic [FRAME_W-1:0]  frame;
      reset = 1'b1;
      req_valid = 1'b0;
      req_bin_re = '0;
      req_bin_im = '0;
      req_position = '0;
      csr_valid = 1'b0;
      csr_index = CSR_AVG_WEIGHT;
      csr_wdata = '0;
      send_burst = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed bins under the reset settings; zero power hits the floor
      send_bin('0, '0, 16'd0);
      send_bin('0, '0, 16'd0);
      // full-scale corners and the top and middle of the position range
      send_bin(BIN_MOST_NEG, BIN_MOST_NEG, 16'hFFFF);
      send_bin(BIN_MOST_POS, BIN_MOST_POS, 16'hFFFF);
      send_bin(BIN_MOST_NEG, BIN_MOST_POS, 16'h8000);
      send_bin(BIN_MOST_POS, '0, 16'd1);
      send_bin('0, BIN_MOST_NEG, 16'd1);
      // smallest nonzero power
      send_bin(24'sd1, '0, 16'd2);
      send_bin('0, -24'sd1, 16'd2);
      send_bin(-24'sd1, 24'sd1, 16'd3);
      // alternating bit patterns
      send_bin(24'h555555, 24'hAAAAAA, 16'h5555);
      send_bin(24'hAAAAAA, 24'h555555, 16'hAAAA);
      // back-to-back updates of one entry
      send_burst = 1'b1;
      for (int k = 0; k < 6; k++) send_bin(random_component(), random_component(), 16'd7);
      send_burst = 1'b0;

      // random phases, each under its own settings written while idle
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         weight = PHASE_WEIGHT[p];
         frame = PHASE_FRAME[p];
         if (p == PHASE_COUNT - 1) begin
            weight = WEIGHT_W'($urandom_range(0, 511));
            frame = FRAME_W'($urandom_range(0, 15));
         end
         write_reg(CSR_AVG_WEIGHT, weight);
         write_reg(CSR_FRAME_LOG2, {5'($urandom), frame});
         write_reg(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom));
         csr_valid <= 1'b0;
         if (p == PRESSURE_PHASE) hold_off_requests <= hold_off_requests + 1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // keep offering during the hold-off so the block fills up
            if (p == PRESSURE_PHASE && k < PRESSURE_ITEMS) send_burst = 1'b1;
            else if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
            send_bin(random_component(), random_component(), random_position());
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bins under %0d weight and frame settings, %0d levels checked.",
               bins_sent, PHASE_COUNT + 1, checked_count);
      $display("Included clamped weights and frame sizes, zero and full-scale power, %s",
               "repeated entries, a long result hold-off and drained pauses.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
